// ===== sv/pfs_pkg.sv =====
package pfs_pkg;

  // Field and datapath widths.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned AttW     = 16;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned SmoothW  = 8;
  localparam int unsigned ShareW   = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned SlopeW   = 24;
  localparam int unsigned FracBits = 23;
  localparam int unsigned IntShift = 15;
  localparam int unsigned OutScale = 100;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Bit-serial multiplier: wide operand, narrow operand walked one bit a cycle.
  localparam int unsigned MulAW = 48;
  localparam int unsigned MulBW = 16;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Bit-serial restoring divider.
  localparam int unsigned DivNW   = 56;
  localparam int unsigned DivDW   = 32;
  localparam int unsigned DivCntW = 6;

  // Signed sum of the four terms.
  localparam int unsigned TermW = 58;

  // Slope difference width and quotient bit counts of the three divisions.
  localparam int unsigned DiffW = SlopeW + 2;
  localparam logic [DivCntW-1:0] DivBitsLim   = DivCntW'(DivNW);
  localparam logic [DivCntW-1:0] DivBitsSlope = DivCntW'(DiffW);
  localparam logic [DivCntW-1:0] DivBitsOut   = DivCntW'(TermW - FracBits);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_GAIN_FF        = 3'd3,
    CFG_OUT_LIMIT      = 3'd4,
    CFG_D_SMOOTHING    = 3'd5,
    CFG_INTEGRAL_SHARE = 3'd6,
    CFG_LOOP_ENABLE    = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_ERR,
    ST_P_ATT,
    ST_FF_SP,
    ST_FF_ATT,
    ST_K,
    ST_LIM_A,
    ST_LIM_B,
    ST_LIM_DIV,
    ST_I_ERR,
    ST_I_ATT,
    ST_D_DIV,
    ST_D_SLOPE,
    ST_D_ATT,
    ST_O_DIV,
    ST_OUT
  } state_e;

  function automatic logic [GainW-1:0] mag_gain(input logic [GainW-1:0] g);
    mag_gain = g[GainW-1] ? GainW'(~g + 1'b1) : g;
  endfunction

endpackage

// ===== sv/pfs_if.sv =====
interface pfs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pfs_pkg::SampleW-1:0]    measurement;
  logic signed [pfs_pkg::SampleW-1:0]    setpoint;
  logic        [pfs_pkg::AttW-1:0]       attenuation;
  logic                                  restart;
  modport source (output valid, measurement, setpoint, attenuation, restart, input ready);
  modport sink   (input valid, measurement, setpoint, attenuation, restart, output ready);
endinterface

interface pfs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pfs_pkg::SampleW-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pfs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfs_pkg::CfgIdxW-1:0]     index;
  logic [pfs_pkg::CfgDataW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pfs_mul.sv =====
module pfs_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pfs_pkg::MulAW-1:0]   a_i,
  input  logic [pfs_pkg::MulBW-1:0]   b_i,
  output logic                        done_o,
  output logic [pfs_pkg::MulPW-1:0]   prod_o
);

  localparam int unsigned CntW = $clog2(pfs_pkg::MulBW);
  localparam logic [CntW-1:0] LastCnt = CntW'(pfs_pkg::MulBW - 1);

  logic [pfs_pkg::MulPW-1:0] a_q;
  logic [pfs_pkg::MulPW-1:0] acc_q;
  logic [pfs_pkg::MulBW-1:0] b_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastCnt);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= pfs_pkg::MulPW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (b_q[0] ? a_q : '0);
      a_q   <= {a_q[pfs_pkg::MulPW-2:0], 1'b0};
      b_q   <= {1'b0, b_q[pfs_pkg::MulBW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/pfs_div.sv =====
module pfs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pfs_pkg::DivNW-1:0]     dividend_i,
  input  logic [pfs_pkg::DivDW-1:0]     divisor_i,
  input  logic [pfs_pkg::DivCntW-1:0]   nbits_i,
  output logic                          done_o,
  output logic [pfs_pkg::DivNW-1:0]     quot_o
);

  // The dividend arrives left aligned in nbits_i bits; after nbits_i steps
  // the quotient sits in the low bits and the zeros of the padding above it.
  logic [pfs_pkg::DivNW-1:0]   dq_q;
  logic [pfs_pkg::DivDW-1:0]   rem_q;
  logic [pfs_pkg::DivDW-1:0]   dvs_q;
  logic [pfs_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [pfs_pkg::DivDW:0]     rem_sh;
  logic [pfs_pkg::DivDW:0]     rem_sub;
  logic                        q_bit;

  assign rem_sh  = {rem_q, dq_q[pfs_pkg::DivNW-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == pfs_pkg::DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == pfs_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= q_bit ? rem_sub[pfs_pkg::DivDW-1:0] : rem_sh[pfs_pkg::DivDW-1:0];
      dq_q  <= {dq_q[pfs_pkg::DivNW-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ===== sv/pid_feedforward_step.sv =====
// PID step with feed-forward and a low-passed derivative. Each input word
// (measurement, setpoint, attenuation in Q1.15, restart) yields one drive
// word: (P + I + D + FF) / 100, truncated toward zero and saturated to plus
// or minus out_limit. All gains are signed Q8.8 and every term is scaled by
// the attenuation. The arithmetic runs through one bit-serial multiplier
// and one restoring divider (one quotient bit per cycle). Integral steps,
// with the 56-bit division for the integral clamp, run only for nonzero
// integral gain and attenuation, derivative steps only for a nonzero
// derivative gain; a word with loop_enable low skips all arithmetic and
// yields drive 0. The block works on one word at a time; a finished drive
// waits in the output register while the next word is already taken.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module pid_feedforward_step (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfs_in_if.sink    in_i,
  pfs_out_if.source out_o,
  pfs_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [pfs_pkg::GainW-1:0]   gain_p_q;
  logic [pfs_pkg::GainW-1:0]   gain_i_q;
  logic [pfs_pkg::GainW-1:0]   gain_d_q;
  logic [pfs_pkg::GainW-1:0]   gain_ff_q;
  logic [pfs_pkg::LimitW-1:0]  out_limit_q;
  logic [pfs_pkg::SmoothW-1:0] d_smoothing_q;
  logic [pfs_pkg::ShareW-1:0]  integral_share_q;
  logic                        loop_enable_q;

  // Loop state.
  logic signed [pfs_pkg::SampleW-1:0] prev_q;
  logic signed [pfs_pkg::SumW-1:0]    es_q;
  logic signed [pfs_pkg::SlopeW-1:0]  slope_q;
  logic                               first_q;

  // Latched word and working registers.
  logic [pfs_pkg::SampleW-1:0] meas_q;
  logic [pfs_pkg::SampleW-1:0] sp_q;
  logic [pfs_pkg::AttW-1:0]    att_q;
  logic [pfs_pkg::MulAW-1:0]   r_q;
  logic [pfs_pkg::DivDW-1:0]   kmag_q;
  logic signed [pfs_pkg::TermW-1:0]   sum_q;
  logic [pfs_pkg::SampleW-1:0] res_q;
  logic                        out_valid_q;
  logic [pfs_pkg::SampleW-1:0] out_drive_q;

  pfs_pkg::state_e state_q, state_d;
  logic            issued_q;

  // Arithmetic unit hookup.
  logic                         mul_start, mul_done;
  logic [pfs_pkg::MulAW-1:0]    mul_a;
  logic [pfs_pkg::MulBW-1:0]    mul_b;
  logic [pfs_pkg::MulPW-1:0]    mul_prod;
  logic                         div_start, div_done;
  logic [pfs_pkg::DivNW-1:0]    div_dividend;
  logic [pfs_pkg::DivDW-1:0]    div_divisor;
  logic [pfs_pkg::DivCntW-1:0]  div_nbits;
  logic [pfs_pkg::DivNW-1:0]    div_quot;
  logic                         is_mul_st, is_div_st;

  logic in_acc, out_free;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Derived operands.
  logic signed [pfs_pkg::SampleW:0]   err;
  logic [pfs_pkg::SampleW:0]          err_mag;
  logic [pfs_pkg::SampleW-1:0]        sp_mag;
  logic [pfs_pkg::SumW-1:0]           es_mag;
  logic [pfs_pkg::SlopeW-1:0]         slope_mag;
  logic signed [pfs_pkg::SumW:0]      es_add;
  logic signed [pfs_pkg::DiffW-1:0]   diff;
  logic [pfs_pkg::DiffW-1:0]          diff_mag;
  logic signed [pfs_pkg::DiffW:0]     q_signed;
  logic signed [pfs_pkg::DiffW:0]     slope_add;
  logic [pfs_pkg::TermW-1:0]          sum_mag;
  logic [pfs_pkg::TermW-1:0]          term;
  logic                               term_neg;
  logic [pfs_pkg::LimitW-1:0]         q_out;
  logic                               gi_nz, gd_nz, att_nz;

  assign gi_nz  = gain_i_q != '0;
  assign gd_nz  = gain_d_q != '0;
  assign att_nz = att_q != '0;

  assign err = $signed({sp_q[pfs_pkg::SampleW-1], sp_q})
             - $signed({meas_q[pfs_pkg::SampleW-1], meas_q});
  assign err_mag   = err[pfs_pkg::SampleW] ? (pfs_pkg::SampleW+1)'(-err)
                                           : (pfs_pkg::SampleW+1)'(err);
  assign sp_mag    = pfs_pkg::mag_gain(sp_q);
  assign es_mag    = es_q[pfs_pkg::SumW-1] ? pfs_pkg::SumW'(-es_q) : pfs_pkg::SumW'(es_q);
  assign slope_mag = slope_q[pfs_pkg::SlopeW-1] ? pfs_pkg::SlopeW'(-slope_q)
                                                : pfs_pkg::SlopeW'(slope_q);
  assign es_add = $signed({es_q[pfs_pkg::SumW-1], es_q})
                + $signed({{(pfs_pkg::SumW-pfs_pkg::SampleW){err[pfs_pkg::SampleW]}}, err});

  // Change of the measurement minus the current slope, then divided by the
  // smoothing divisor with the magnitude taken through the divider.
  assign diff = $signed({{(pfs_pkg::DiffW-pfs_pkg::SampleW){meas_q[pfs_pkg::SampleW-1]}}, meas_q})
              - $signed({{(pfs_pkg::DiffW-pfs_pkg::SampleW){prev_q[pfs_pkg::SampleW-1]}}, prev_q})
              - $signed({{(pfs_pkg::DiffW-pfs_pkg::SlopeW){slope_q[pfs_pkg::SlopeW-1]}}, slope_q});
  assign diff_mag = diff[pfs_pkg::DiffW-1] ? pfs_pkg::DiffW'(-diff) : pfs_pkg::DiffW'(diff);
  assign q_signed = diff[pfs_pkg::DiffW-1]
                  ? -$signed({1'b0, div_quot[pfs_pkg::DiffW-1:0]})
                  :  $signed({1'b0, div_quot[pfs_pkg::DiffW-1:0]});
  assign slope_add = q_signed
                   + $signed({{(pfs_pkg::DiffW+1-pfs_pkg::SlopeW){slope_q[pfs_pkg::SlopeW-1]}},
                              slope_q});

  assign sum_mag = sum_q[pfs_pkg::TermW-1] ? pfs_pkg::TermW'(-sum_q) : pfs_pkg::TermW'(sum_q);
  assign term    = {1'b0, mul_prod[pfs_pkg::TermW-2:0]};
  assign q_out   = (div_quot > pfs_pkg::DivNW'(out_limit_q)) ? out_limit_q
                                                              : div_quot[pfs_pkg::LimitW-1:0];

  always_comb begin
    case (state_q)
      pfs_pkg::ST_P_ATT:   term_neg = err[pfs_pkg::SampleW] ^ gain_p_q[pfs_pkg::GainW-1];
      pfs_pkg::ST_FF_ATT:  term_neg = sp_q[pfs_pkg::SampleW-1] ^ gain_ff_q[pfs_pkg::GainW-1];
      pfs_pkg::ST_I_ATT:   term_neg = es_q[pfs_pkg::SumW-1] ^ gain_i_q[pfs_pkg::GainW-1];
      default:             term_neg = slope_q[pfs_pkg::SlopeW-1] ^ gain_d_q[pfs_pkg::GainW-1];
    endcase
  end

  // Configuration port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q         <= '0;
      gain_i_q         <= '0;
      gain_d_q         <= '0;
      gain_ff_q        <= '0;
      out_limit_q      <= '1;
      d_smoothing_q    <= '0;
      integral_share_q <= pfs_pkg::ShareW'(256);
      loop_enable_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (pfs_pkg::cfg_idx_e'(cfg_i.index))
        pfs_pkg::CFG_GAIN_P:         gain_p_q <= cfg_i.data[pfs_pkg::GainW-1:0];
        pfs_pkg::CFG_GAIN_I:         gain_i_q <= cfg_i.data[pfs_pkg::GainW-1:0];
        pfs_pkg::CFG_GAIN_D:         gain_d_q <= cfg_i.data[pfs_pkg::GainW-1:0];
        pfs_pkg::CFG_GAIN_FF:        gain_ff_q <= cfg_i.data[pfs_pkg::GainW-1:0];
        pfs_pkg::CFG_OUT_LIMIT:      out_limit_q <= cfg_i.data[pfs_pkg::LimitW-1:0];
        pfs_pkg::CFG_D_SMOOTHING:    d_smoothing_q <= cfg_i.data[pfs_pkg::SmoothW-1:0];
        pfs_pkg::CFG_INTEGRAL_SHARE: integral_share_q <= cfg_i.data[pfs_pkg::ShareW-1:0];
        pfs_pkg::CFG_LOOP_ENABLE:    loop_enable_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfs_pkg::ST_IDLE:
        if (in_acc) begin
          state_d = loop_enable_q ? pfs_pkg::ST_P_ERR : pfs_pkg::ST_OUT;
        end
      pfs_pkg::ST_P_ERR:   if (mul_done) state_d = pfs_pkg::ST_P_ATT;
      pfs_pkg::ST_P_ATT:   if (mul_done) state_d = pfs_pkg::ST_FF_SP;
      pfs_pkg::ST_FF_SP:   if (mul_done) state_d = pfs_pkg::ST_FF_ATT;
      pfs_pkg::ST_FF_ATT:
        if (mul_done) begin
          if (gi_nz && att_nz) begin
            state_d = pfs_pkg::ST_K;
          end else begin
            state_d = gd_nz ? pfs_pkg::ST_D_DIV : pfs_pkg::ST_O_DIV;
          end
        end
      pfs_pkg::ST_K:       if (mul_done) state_d = pfs_pkg::ST_LIM_A;
      pfs_pkg::ST_LIM_A:   if (mul_done) state_d = pfs_pkg::ST_LIM_B;
      pfs_pkg::ST_LIM_B:   if (mul_done) state_d = pfs_pkg::ST_LIM_DIV;
      pfs_pkg::ST_LIM_DIV: if (div_done) state_d = pfs_pkg::ST_I_ERR;
      pfs_pkg::ST_I_ERR:   if (mul_done) state_d = pfs_pkg::ST_I_ATT;
      pfs_pkg::ST_I_ATT:
        if (mul_done) begin
          state_d = gd_nz ? pfs_pkg::ST_D_DIV : pfs_pkg::ST_O_DIV;
        end
      pfs_pkg::ST_D_DIV:   if (div_done) state_d = pfs_pkg::ST_D_SLOPE;
      pfs_pkg::ST_D_SLOPE: if (mul_done) state_d = pfs_pkg::ST_D_ATT;
      pfs_pkg::ST_D_ATT:   if (mul_done) state_d = pfs_pkg::ST_O_DIV;
      pfs_pkg::ST_O_DIV:   if (div_done) state_d = pfs_pkg::ST_OUT;
      pfs_pkg::ST_OUT:     if (out_free) state_d = pfs_pkg::ST_IDLE;
      default:             state_d = pfs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs and operand selection.
  always_comb begin
    in_i.ready   = state_q == pfs_pkg::ST_IDLE;
    is_mul_st    = 1'b0;
    is_div_st    = 1'b0;
    mul_a        = pfs_pkg::MulAW'(att_q);
    mul_b        = att_q;
    div_dividend = {sum_mag[pfs_pkg::TermW-1:pfs_pkg::FracBits],
                    {(pfs_pkg::DivNW-pfs_pkg::TermW+pfs_pkg::FracBits){1'b0}}};
    div_divisor  = pfs_pkg::DivDW'(pfs_pkg::OutScale);
    div_nbits    = pfs_pkg::DivBitsOut;
    unique case (state_q) inside
      pfs_pkg::ST_P_ERR: begin
        is_mul_st = 1'b1;
        mul_a     = pfs_pkg::MulAW'(err_mag);
        mul_b     = pfs_pkg::mag_gain(gain_p_q);
      end
      pfs_pkg::ST_FF_SP: begin
        is_mul_st = 1'b1;
        mul_a     = pfs_pkg::MulAW'(sp_mag);
        mul_b     = pfs_pkg::mag_gain(gain_ff_q);
      end
      pfs_pkg::ST_P_ATT, pfs_pkg::ST_FF_ATT, pfs_pkg::ST_I_ATT, pfs_pkg::ST_D_ATT: begin
        is_mul_st = 1'b1;
        mul_a     = r_q;
        mul_b     = att_q;
      end
      pfs_pkg::ST_K: begin
        is_mul_st = 1'b1;
        mul_a     = pfs_pkg::MulAW'(att_q);
        mul_b     = pfs_pkg::mag_gain(gain_i_q);
      end
      pfs_pkg::ST_LIM_A: begin
        is_mul_st = 1'b1;
        mul_a     = pfs_pkg::MulAW'(out_limit_q);
        mul_b     = integral_share_q;
      end
      pfs_pkg::ST_LIM_B: begin
        is_mul_st = 1'b1;
        mul_a     = r_q;
        mul_b     = pfs_pkg::MulBW'(pfs_pkg::OutScale);
      end
      pfs_pkg::ST_I_ERR: begin
        is_mul_st = 1'b1;
        mul_a     = pfs_pkg::MulAW'(es_mag);
        mul_b     = pfs_pkg::mag_gain(gain_i_q);
      end
      pfs_pkg::ST_D_SLOPE: begin
        is_mul_st = 1'b1;
        mul_a     = pfs_pkg::MulAW'(slope_mag);
        mul_b     = pfs_pkg::mag_gain(gain_d_q);
      end
      pfs_pkg::ST_LIM_DIV: begin
        is_div_st    = 1'b1;
        div_dividend = pfs_pkg::DivNW'({r_q, {pfs_pkg::IntShift{1'b0}}});
        div_divisor  = kmag_q;
        div_nbits    = pfs_pkg::DivBitsLim;
      end
      pfs_pkg::ST_D_DIV: begin
        is_div_st    = 1'b1;
        div_dividend = {diff_mag, {(pfs_pkg::DivNW-pfs_pkg::DiffW){1'b0}}};
        div_divisor  = pfs_pkg::DivDW'(d_smoothing_q) + 1'b1;
        div_nbits    = pfs_pkg::DivBitsSlope;
      end
      pfs_pkg::ST_O_DIV: begin
        is_div_st = 1'b1;
      end
      default: ;
    endcase
    mul_start = is_mul_st && !issued_q;
    div_start = is_div_st && !issued_q;
  end

  pfs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .nbits_i    (div_nbits),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Control state and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfs_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      es_q        <= '0;
      slope_q     <= '0;
      first_q     <= 1'b1;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end else if (mul_done || div_done) begin
        issued_q <= 1'b0;
      end

      if (state_q == pfs_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        // A disabled loop resets the state; a restart clears sum and slope, and
        // it or the first enabled sample seeds the previous measurement.
        if (!loop_enable_q) begin
          prev_q  <= '0;
          es_q    <= '0;
          slope_q <= '0;
          first_q <= 1'b1;
        end else begin
          if (in_i.restart || first_q) begin
            prev_q <= in_i.measurement;
          end
          if (in_i.restart) begin
            es_q    <= '0;
            slope_q <= '0;
          end
          first_q <= 1'b0;
        end
      end

      if (state_q == pfs_pkg::ST_FF_ATT && mul_done) begin
        if (!gi_nz) begin
          es_q <= '0;
        end else if (es_add[pfs_pkg::SumW] != es_add[pfs_pkg::SumW-1]) begin
          es_q <= {es_add[pfs_pkg::SumW], {(pfs_pkg::SumW-1){~es_add[pfs_pkg::SumW]}}};
        end else begin
          es_q <= es_add[pfs_pkg::SumW-1:0];
        end
        if (!gd_nz) begin
          slope_q <= '0;
        end
      end

      // Clamp the accumulator to the quotient of the integral limit.
      if (state_q == pfs_pkg::ST_LIM_DIV && div_done) begin
        if (pfs_pkg::DivNW'(es_mag) > div_quot) begin
          es_q <= es_q[pfs_pkg::SumW-1] ? -$signed(pfs_pkg::SumW'(div_quot))
                                        :  $signed(pfs_pkg::SumW'(div_quot));
        end
      end

      if (state_q == pfs_pkg::ST_D_DIV && div_done) begin
        if (slope_add[pfs_pkg::DiffW:pfs_pkg::SlopeW-1] != '0 &&
            slope_add[pfs_pkg::DiffW:pfs_pkg::SlopeW-1] != '1) begin
          slope_q <= {slope_add[pfs_pkg::DiffW],
                      {(pfs_pkg::SlopeW-1){~slope_add[pfs_pkg::DiffW]}}};
        end else begin
          slope_q <= slope_add[pfs_pkg::SlopeW-1:0];
        end
      end

      if (state_q == pfs_pkg::ST_O_DIV && div_done) begin
        prev_q <= meas_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= in_i.measurement;
      sp_q   <= in_i.setpoint;
      att_q  <= in_i.attenuation;
      sum_q  <= '0;
      res_q  <= '0;
    end
    if (mul_done) begin
      unique case (state_q) inside
        pfs_pkg::ST_K:
          kmag_q <= mul_prod[pfs_pkg::DivDW-1:0];
        pfs_pkg::ST_P_ATT, pfs_pkg::ST_FF_ATT, pfs_pkg::ST_I_ATT, pfs_pkg::ST_D_ATT:
          sum_q <= term_neg ? sum_q - $signed(term) : sum_q + $signed(term);
        default:
          r_q <= mul_prod[pfs_pkg::MulAW-1:0];
      endcase
    end
    if (state_q == pfs_pkg::ST_O_DIV && div_done) begin
      res_q <= sum_q[pfs_pkg::TermW-1] ? pfs_pkg::SampleW'(-{1'b0, q_out})
                                       : pfs_pkg::SampleW'({1'b0, q_out});
    end
    if (state_q == pfs_pkg::ST_OUT && out_free) begin
      out_drive_q <= res_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.drive = out_drive_q;

  // A word is only taken while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == pfs_pkg::ST_IDLE)
    else $error("input taken outside idle");

  // The multiplier only reports completion in a state that waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> is_mul_st && issued_q)
    else $error("multiplier done without a waiting state");

  // The divider only reports completion in a state that waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == pfs_pkg::ST_LIM_DIV || state_q == pfs_pkg::ST_D_DIV ||
                  state_q == pfs_pkg::ST_O_DIV) && issued_q)
    else $error("divider done without a waiting state");

  // Leaving the result state always presents a word on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfs_pkg::ST_OUT && out_free) |=> out_valid_q)
    else $error("result lost on the way to the output");

  // The drive never exceeds the configured magnitude limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($signed(out_drive_q) <= $signed({1'b0, out_limit_q}) &&
                            $signed(out_drive_q) >= -$signed({1'b0, out_limit_q})))
    else $error("drive outside the output limit");

endmodule
